/* rtl/rrft_pkg.sv */
// Shared constants and types for the reader rank fraction tracker.
package rrft_pkg;

	localparam int USER_W     = 16;
	localparam int PAGE_W     = 10;
	localparam int CNT_W      = 17;
	localparam int FRAC_W     = 16;
	localparam int SUM_W      = CNT_W + PAGE_W;
	localparam int QUO_W      = SUM_W + FRAC_W;
	localparam int DIV_CNT_W  = $clog2(QUO_W);
	localparam int USER_DEPTH = 2 ** USER_W;
	localparam int HIST_DEPTH = 2 ** PAGE_W;

	localparam int MAX_USERS = 65536;
	localparam int MAX_PAGES = 1023;

	localparam logic [USER_W:0]   USER_LIMIT = (USER_W + 1)'(MAX_USERS);
	localparam logic [PAGE_W-1:0] PAGE_MAX   = PAGE_W'(MAX_PAGES);
	localparam logic [CNT_W-1:0]  FRAC_ONE   = CNT_W'(2 ** FRAC_W);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_DEC_RD,
		ST_DEC_WR,
		ST_INC_RD,
		ST_INC_WR,
		ST_SUM,
		ST_DIV,
		ST_RESULT
	} state_t;

endpackage

/* rtl/reader_rank_fraction_tracker.sv */
// A read word passes LOOKUP and, if it changes the user's count, DEC_RD and DEC_WR (old count
// not zero), INC_RD and INC_WR: RMW on the user RAM and one or two histogram bins over one
// write port. A cheer word passes LOOKUP, then SUM and DIV if it needs the bin walk, then
// RESULT. One word is in flight at a time; a cheer walks the histogram RAM one bin per cycle,
// then a 43-step restoring divider runs one quotient bit per cycle. After arst_n the user and
// histogram RAMs are cleared, one entry per cycle, with in_stall high until the clear ends.
module reader_rank_fraction_tracker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [rrft_pkg::USER_W-1:0] user_id,
	input  logic [rrft_pkg::PAGE_W-1:0] pages,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rrft_pkg::CNT_W-1:0]  fraction
);

	rrft_pkg::state_t state_q, state_d;

	logic [rrft_pkg::PAGE_W-1:0] user_mem [rrft_pkg::USER_DEPTH];
	logic [rrft_pkg::CNT_W-1:0]  hist_mem [rrft_pkg::HIST_DEPTH];

	logic [rrft_pkg::PAGE_W-1:0] user_rd_q;
	logic [rrft_pkg::CNT_W-1:0]  hist_rd_q;

	logic                        user_we;
	logic [rrft_pkg::USER_W-1:0] user_waddr;
	logic [rrft_pkg::PAGE_W-1:0] user_wdata;
	logic                        hist_we;
	logic [rrft_pkg::PAGE_W-1:0] hist_waddr;
	logic [rrft_pkg::CNT_W-1:0]  hist_wdata;
	logic [rrft_pkg::PAGE_W-1:0] hist_raddr;

	logic [rrft_pkg::USER_W-1:0] clr_q;
	logic [rrft_pkg::CNT_W-1:0]  active_q;
	logic                        out_valid_q;
	logic [rrft_pkg::CNT_W-1:0]  fraction_q;

	logic                        kind_q;
	logic [rrft_pkg::USER_W-1:0] uid_q;
	logic [rrft_pkg::PAGE_W-1:0] pages_q;
	logic [rrft_pkg::PAGE_W-1:0] old_q;
	logic [rrft_pkg::PAGE_W-1:0] idx_q;
	logic                        pend_q;
	logic [rrft_pkg::SUM_W-1:0]  less_q;
	logic [rrft_pkg::QUO_W-1:0]  dq_q;
	logic [rrft_pkg::CNT_W-1:0]  rem_q;
	logic [rrft_pkg::DIV_CNT_W-1:0] div_cnt_q;

	logic                        uid_ok;
	logic                        read_upd;
	logic                        cheer_now;
	logic                        sum_more;
	logic                        out_free;
	logic [rrft_pkg::CNT_W-1:0]  others;
	logic [rrft_pkg::CNT_W:0]    div_t;
	logic                        div_ge;
	logic [rrft_pkg::CNT_W:0]    div_r;
	logic [rrft_pkg::CNT_W-1:0]  frac_clamp;

	assign uid_ok    = {1'b0, uid_q} < rrft_pkg::USER_LIMIT;
	assign read_upd  = !kind_q && uid_ok && (pages_q != '0) && (user_rd_q != pages_q);
	// cheer needs the bin walk only when the user is known and has company
	assign cheer_now = uid_ok && (user_rd_q != '0)
		&& (active_q > rrft_pkg::CNT_W'(1));
	assign sum_more  = idx_q < old_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign others    = active_q - rrft_pkg::CNT_W'(1);

	assign div_t  = {rem_q, dq_q[rrft_pkg::QUO_W-1]};
	assign div_ge = div_t >= {1'b0, others};
	assign div_r  = div_ge ? div_t - {1'b0, others} : div_t;

	assign frac_clamp = (dq_q > rrft_pkg::QUO_W'(rrft_pkg::FRAC_ONE)) ?
		rrft_pkg::FRAC_ONE : dq_q[rrft_pkg::CNT_W-1:0];

	assign in_stall  = state_q != rrft_pkg::ST_IDLE;
	assign out_valid = out_valid_q;
	assign fraction  = fraction_q;

	// memories
	always_ff @(posedge clk) begin
		if (user_we) begin
			user_mem[user_waddr] <= user_wdata;
		end
		user_rd_q <= user_mem[user_id];
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		hist_rd_q <= hist_mem[hist_raddr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rrft_pkg::ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = rrft_pkg::ST_IDLE;
				end
			end
			rrft_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = rrft_pkg::ST_LOOKUP;
				end
			end
			rrft_pkg::ST_LOOKUP: begin
				if (!kind_q) begin
					if (!read_upd) begin
						state_d = rrft_pkg::ST_IDLE;
					end else if (user_rd_q == '0) begin
						state_d = rrft_pkg::ST_INC_RD;
					end else begin
						state_d = rrft_pkg::ST_DEC_RD;
					end
				end else if (cheer_now) begin
					state_d = rrft_pkg::ST_SUM;
				end else begin
					state_d = rrft_pkg::ST_RESULT;
				end
			end
			rrft_pkg::ST_DEC_RD: state_d = rrft_pkg::ST_DEC_WR;
			rrft_pkg::ST_DEC_WR: state_d = rrft_pkg::ST_INC_RD;
			rrft_pkg::ST_INC_RD: state_d = rrft_pkg::ST_INC_WR;
			rrft_pkg::ST_INC_WR: state_d = rrft_pkg::ST_IDLE;
			rrft_pkg::ST_SUM: begin
				if (!sum_more && !pend_q) begin
					state_d = rrft_pkg::ST_DIV;
				end
			end
			rrft_pkg::ST_DIV: begin
				if (div_cnt_q == rrft_pkg::DIV_CNT_W'(rrft_pkg::QUO_W - 1)) begin
					state_d = rrft_pkg::ST_RESULT;
				end
			end
			rrft_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = rrft_pkg::ST_IDLE;
				end
			end
			default: state_d = rrft_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		user_we    = 1'b0;
		user_waddr = uid_q;
		user_wdata = pages_q;
		hist_we    = 1'b0;
		hist_waddr = old_q;
		hist_wdata = hist_rd_q - rrft_pkg::CNT_W'(1);
		hist_raddr = idx_q;
		unique case (state_q)
			rrft_pkg::ST_CLEAR: begin
				user_we    = 1'b1;
				user_waddr = clr_q;
				user_wdata = '0;
				hist_we    = 1'b1;
				hist_waddr = clr_q[rrft_pkg::PAGE_W-1:0];
				hist_wdata = '0;
			end
			rrft_pkg::ST_LOOKUP: begin
				user_we = read_upd;
			end
			rrft_pkg::ST_DEC_RD: begin
				hist_raddr = old_q;
			end
			rrft_pkg::ST_DEC_WR: begin
				hist_we = 1'b1;
			end
			rrft_pkg::ST_INC_RD: begin
				hist_raddr = pages_q;
			end
			rrft_pkg::ST_INC_WR: begin
				hist_we    = 1'b1;
				hist_waddr = pages_q;
				hist_wdata = hist_rd_q + rrft_pkg::CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrft_pkg::ST_CLEAR;
			clr_q       <= '0;
			active_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rrft_pkg::ST_CLEAR) begin
				clr_q <= clr_q + rrft_pkg::USER_W'(1);
			end
			if (state_q == rrft_pkg::ST_LOOKUP && read_upd && user_rd_q == '0) begin
				active_q <= active_q + rrft_pkg::CNT_W'(1);
			end
			if (state_q == rrft_pkg::ST_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rrft_pkg::ST_RESULT && out_free) begin
			fraction_q <= frac_clamp;
		end
	end

	// word capture, bin walk and divider
	always_ff @(posedge clk) begin
		unique case (state_q)
			rrft_pkg::ST_IDLE: begin
				if (in_valid) begin
					kind_q  <= kind;
					uid_q   <= user_id;
					pages_q <= (pages > rrft_pkg::PAGE_MAX) ? rrft_pkg::PAGE_MAX
						: pages;
				end
			end
			rrft_pkg::ST_LOOKUP: begin
				old_q  <= user_rd_q;
				idx_q  <= rrft_pkg::PAGE_W'(1);
				pend_q <= 1'b0;
				less_q <= '0;
				// unknown user reads 0, lone user reads 1.0
				dq_q   <= (!uid_ok || user_rd_q == '0) ? '0
					: rrft_pkg::QUO_W'(rrft_pkg::FRAC_ONE);
			end
			rrft_pkg::ST_SUM: begin
				if (pend_q) begin
					less_q <= less_q + rrft_pkg::SUM_W'(hist_rd_q);
				end
				if (sum_more) begin
					idx_q  <= idx_q + rrft_pkg::PAGE_W'(1);
					pend_q <= 1'b1;
				end else begin
					pend_q <= 1'b0;
				end
				if (!sum_more && !pend_q) begin
					dq_q      <= {less_q, rrft_pkg::FRAC_W'(0)};
					rem_q     <= '0;
					div_cnt_q <= '0;
				end
			end
			rrft_pkg::ST_DIV: begin
				rem_q     <= div_r[rrft_pkg::CNT_W-1:0];
				dq_q      <= {dq_q[rrft_pkg::QUO_W-2:0], div_ge};
				div_cnt_q <= div_cnt_q + rrft_pkg::DIV_CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/rrft_checker.sv */
// Port-level checks for the reader rank fraction tracker, bound to the top level.
module rrft_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        kind,
	input logic [rrft_pkg::USER_W-1:0] user_id,
	input logic [rrft_pkg::PAGE_W-1:0] pages,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [rrft_pkg::CNT_W-1:0]  fraction
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(fraction))
		else $error("result word changed while stalled");

	// a stalled input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(kind) && $stable(user_id)
			&& $stable(pages))
		else $error("input word changed while stalled");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fraction <= rrft_pkg::FRAC_ONE)
		else $error("fraction above 1.0");

	// one word in flight at a time
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on back-to-back cycles");

	// a new result only comes out of a busy block
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while idle");

endmodule

bind reader_rank_fraction_tracker rrft_checker u_rrft_checker (.*);
